/* rtl/core/ddmr_pkg.sv */
package ddmr_pkg;

  localparam int FracBits = 14;
  localparam int OpW = 20;
  localparam int PrW = 2 * OpW;
  localparam int MqW = 26;
  localparam logic signed [15:0] One = 16'sd16384;
  localparam logic [15:0] ZeroThreshold = 16'd164;
  localparam logic signed [15:0] BrakeZero = 16'((16384 + 5) / 10);
  localparam logic signed [15:0] PMax = 16'sd32767;

  localparam logic [2:0] RegDeadzone = 3'd0;
  localparam logic [2:0] RegBoost    = 3'd1;
  localparam logic [2:0] RegNormal   = 3'd2;
  localparam logic [2:0] RegSlow     = 3'd3;
  localparam logic [2:0] RegOffset   = 3'd4;
  localparam logic [2:0] RegAccel    = 3'd5;
  localparam logic [2:0] RegBrake    = 3'd6;
  localparam logic [2:0] RegInterval = 3'd7;

  localparam logic [1:0] ModeBoost  = 2'd0;
  localparam logic [1:0] ModeNormal = 2'd1;
  localparam logic [1:0] ModeSlow   = 2'd2;

  typedef struct packed {
    logic [7:0]  left_stick_y;
    logic [7:0]  right_stick_x;
    logic [1:0]  speed_mode;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic signed [15:0] left_power;
    logic signed [15:0] right_power;
    logic [11:0]        left_pulse_us;
  } out_t;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_MAP   = 10'b0000000010,
    ST_MIX   = 10'b0000000100,
    ST_INA   = 10'b0000001000,
    ST_INB   = 10'b0000010000,
    ST_INC   = 10'b0000100000,
    ST_IND   = 10'b0001000000,
    ST_RAMPL = 10'b0010000000,
    ST_RAMPR = 10'b0100000000,
    ST_PULSE = 10'b1000000000
  } state_e;

  // rounded fixed-point product, half away from zero
  function automatic logic signed [MqW-1:0] mulq(input logic signed [OpW-1:0] a,
                                                 input logic signed [OpW-1:0] b);
    logic signed [PrW-1:0] p;
    logic [PrW-1:0] m;
    logic [PrW-1:0] r;
    p = a * b;
    m = p[PrW-1] ? PrW'(-p) : PrW'(p);
    r = (m + (PrW'(1) << (FracBits - 1))) >> FracBits;
    return p[PrW-1] ? -$signed(r[MqW-1:0]) : $signed(r[MqW-1:0]);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [MqW-1:0] a);
    if (a > MqW'(PMax)) return PMax;
    if (a < -MqW'(PMax)) return -PMax;
    return a[15:0];
  endfunction

  // stick byte offset to q2.14 magnitude, round(a * 16384 / 255)
  function automatic logic [15:0] stick_mag(input logic [7:0] a);
    logic [15:0] w;
    logic [15:0] q;
    w = {2'b0, a, 6'b0} + 16'd127;
    q = (w + 16'd1 + (w >> 8)) >> 8;
    return {2'b0, a, 6'b0} + q;
  endfunction

endpackage

/* rtl/core/differential_drive_mixer_ramp_top.sv */
// Differential-drive mixer with per-motor ramping. Each transaction carries two stick
// bytes, a speed mode and a millisecond timestamp; one result with both ramped powers
// (signed Q2.14) and the left servo pulse width comes back per transaction. One rounded
// multiplier is shared by a sequencer: a transaction steps from acceptance through the map
// and mix states, the turn states INA to IND only for a curved turn (not for stop, straight or
// spin moves), the ramp states RAMPL and RAMPR and the pulse state to the result register, then back
// to idle before the next is accepted. A result still waiting at the output holds the last
// step until it is taken, and in_ready_o is high only between transactions. Configuration
// writes are taken at any cycle with cfg_we_i high and should happen only while idle.
module differential_drive_mixer_ramp_top
  import ddmr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o
);

  logic [14:0] deadzone_q, boost_q, normal_q, slow_q, offset_q, accel_q, brake_q;
  logic [15:0] interval_q;

  state_e state_q, state_d;
  in_t in_q;
  logic signed [15:0] f_q, t_q;
  logic [14:0] s_q;
  logic signed [15:0] base_q;
  logic [17:0] ta_q, tb_q, tc_q;
  logic signed [19:0] rl_q, rr_q;
  logic signed [15:0] pl_q, pr_q;
  logic signed [15:0] ramp_power_q [2];
  logic [31:0] ramp_time_q [2];
  logic signed [15:0] last_out_q [2];
  logic signed [15:0] ltv_q;
  logic out_valid_q;
  out_t out_q;

  logic signed [OpW-1:0] op_a, op_b;
  logic signed [MqW-1:0] mq;
  logic signed [9:0] num_f, num_t;
  logic [15:0] mag_f, mag_t;
  logic signed [15:0] f_d, t_d;
  logic [15:0] abs_f, abs_t, abs_prev;
  logic signed [15:0] prev;
  logic [14:0] off;
  logic tank, curved;
  logic signed [MqW-1:0] v_s;

  logic mot;
  logic signed [MqW-1:0] r26, c26, d26, absr, absd;
  logic [31:0] dt;
  logic signed [15:0] ramp_out, ramp_new;
  logic ramp_upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q <= 15'd1638;
      boost_q    <= 15'd16384;
      normal_q   <= 15'd9830;
      slow_q     <= 15'd4915;
      offset_q   <= 15'd3277;
      accel_q    <= 15'd164;
      brake_q    <= 15'd13107;
      interval_q <= 16'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegDeadzone: deadzone_q <= cfg_wdata_i[14:0];
        RegBoost:    boost_q    <= cfg_wdata_i[14:0];
        RegNormal:   normal_q   <= cfg_wdata_i[14:0];
        RegSlow:     slow_q     <= cfg_wdata_i[14:0];
        RegOffset:   offset_q   <= cfg_wdata_i[14:0];
        RegAccel:    accel_q    <= cfg_wdata_i[14:0];
        RegBrake:    brake_q    <= cfg_wdata_i[14:0];
        RegInterval: interval_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stick mapping
  always_comb begin
    num_f = 10'sd255 - $signed({1'b0, in_q.left_stick_y, 1'b0});
    num_t = $signed({1'b0, in_q.right_stick_x, 1'b0}) - 10'sd255;
    mag_f = stick_mag(num_f[9] ? 8'(-num_f) : num_f[7:0]);
    mag_t = stick_mag(num_t[9] ? 8'(-num_t) : num_t[7:0]);
    if (mag_f < {1'b0, deadzone_q}) f_d = '0;
    else f_d = num_f[9] ? -$signed(mag_f) : $signed(mag_f);
    if (mag_t < {1'b0, deadzone_q}) t_d = '0;
    else t_d = num_t[9] ? -$signed(mag_t) : $signed(mag_t);
  end

  always_comb begin
    abs_f = f_q[15] ? 16'(-f_q) : f_q;
    abs_t = t_q[15] ? 16'(-t_q) : t_q;
    prev = t_q[15] ? last_out_q[1] : last_out_q[0];
    abs_prev = prev[15] ? 16'(-prev) : prev;
    off = (offset_q > 15'(One)) ? '0 : 15'(One) - offset_q;
    tank = (f_q == 0) && (t_q != 0) && (ltv_q == 0);
    curved = (t_q != 0) && !tank;
  end

  // shared multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_q)
      ST_MIX: begin
        op_a = $signed({5'b0, s_q});
        op_b = tank ? OpW'(t_q) : OpW'(f_q);
      end
      ST_INA: begin
        op_a = $signed({4'b0, abs_f});
        op_b = $signed({5'b0, off});
      end
      ST_INB: begin
        op_a = OpW'(prev);
        op_b = OpW'(prev);
      end
      ST_INC: begin
        op_a = $signed({2'b0, ta_q});
        op_b = $signed({2'b0, tb_q});
      end
      ST_IND: begin
        op_a = OpW'(One) - $signed({4'b0, abs_t});
        op_b = $signed({4'b0, abs_prev});
      end
      ST_RAMPL: begin
        op_a = OpW'(ramp_power_q[0]);
        op_b = $signed({5'b0, brake_q});
      end
      ST_RAMPR: begin
        op_a = OpW'(ramp_power_q[1]);
        op_b = $signed({5'b0, brake_q});
      end
      ST_PULSE: begin
        op_a = OpW'(pl_q);
        op_b = OpW'(500);
      end
      default: ;
    endcase
  end

  assign mq = mulq(op_a, op_b);
  assign v_s = prev[15] ? -(MqW'(tc_q) + mq) : (MqW'(tc_q) + mq);

  // ramp of the current motor
  always_comb begin
    mot = (state_q == ST_RAMPR);
    r26 = mot ? MqW'(rr_q) : MqW'(rl_q);
    c26 = MqW'(ramp_power_q[mot]);
    d26 = r26 - c26;
    absr = r26[MqW-1] ? -r26 : r26;
    absd = d26[MqW-1] ? -d26 : d26;
    dt = in_q.now_ms - ramp_time_q[mot];
    ramp_out = ramp_power_q[mot];
    ramp_new = ramp_power_q[mot];
    ramp_upd = 1'b0;
    if (dt >= {16'd0, interval_q}) begin
      if (absr < MqW'(ZeroThreshold)) begin
        ramp_upd = 1'b1;
        if (c26 < MqW'(BrakeZero) && c26 > -MqW'(BrakeZero)) ramp_new = '0;
        else ramp_new = sat16(mq);
        ramp_out = ramp_new;
      end else if (absd < MqW'(accel_q)) begin
        ramp_out = sat16(r26);
      end else begin
        ramp_upd = 1'b1;
        ramp_new = (r26 > c26) ? sat16(c26 + MqW'(accel_q)) : sat16(c26 - MqW'(accel_q));
        ramp_out = ramp_new;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_MAP;
      ST_MAP:   state_d = ST_MIX;
      ST_MIX:   state_d = curved ? ST_INA : ST_RAMPL;
      ST_INA:   state_d = ST_INB;
      ST_INB:   state_d = ST_INC;
      ST_INC:   state_d = ST_IND;
      ST_IND:   state_d = ST_RAMPL;
      ST_RAMPL: state_d = ST_RAMPR;
      ST_RAMPR: state_d = ST_PULSE;
      ST_PULSE: if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_valid_q <= 1'b0;
      ramp_power_q[0] <= '0;
      ramp_power_q[1] <= '0;
      ramp_time_q[0] <= '0;
      ramp_time_q[1] <= '0;
      last_out_q[0] <= '0;
      last_out_q[1] <= '0;
      ltv_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_PULSE && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (state_q == ST_IND) ltv_q <= sat16(v_s);
      if ((state_q == ST_RAMPL || state_q == ST_RAMPR) && ramp_upd) begin
        ramp_power_q[mot] <= ramp_new;
        ramp_time_q[mot] <= in_q.now_ms;
      end
      if (state_q == ST_RAMPL || state_q == ST_RAMPR) last_out_q[mot] <= ramp_out;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) in_q <= in_data_i;
    if (state_q == ST_MAP) begin
      f_q <= f_d;
      t_q <= t_d;
      case (in_q.speed_mode)
        ModeBoost:  s_q <= boost_q;
        ModeNormal: s_q <= normal_q;
        ModeSlow:   s_q <= slow_q;
        default:    s_q <= '0;
      endcase
    end
    if (state_q == ST_MIX) begin
      base_q <= mq[15:0];
      rl_q <= 20'(mq);
      rr_q <= tank ? 20'(-mq) : 20'(mq);
    end
    if (state_q == ST_INA) ta_q <= mq[17:0];
    if (state_q == ST_INB) tb_q <= mq[17:0];
    if (state_q == ST_INC) tc_q <= mq[17:0];
    if (state_q == ST_IND) begin
      if (t_q[15]) begin
        rl_q <= 20'(v_s);
        rr_q <= 20'(base_q);
      end else begin
        rl_q <= 20'(base_q);
        rr_q <= 20'(v_s);
      end
    end
    if (state_q == ST_RAMPL) pl_q <= ramp_out;
    if (state_q == ST_RAMPR) pr_q <= ramp_out;
    if (state_q == ST_PULSE && (!out_valid_q || out_ready_i)) begin
      out_q.left_power <= pl_q;
      out_q.right_power <= pr_q;
      out_q.left_pulse_us <= 12'(MqW'(1500) + mq);
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  a_accept_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_MAP)
    else $error("accepted transaction did not start mapping");

  a_ltv_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ltv_q != -16'sd32768)
    else $error("turn value outside saturation range");

  a_ramp_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ramp_power_q[0] != -16'sd32768 && ramp_power_q[1] != -16'sd32768)
    else $error("ramp power outside saturation range");

  a_pulse_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PULSE && out_valid_q && !out_ready_i |=> state_q == ST_PULSE)
    else $error("result overwrote pending output");

endmodule
